@@ rtl/booth_sequential_multiplier_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOOTH_SEQUENTIAL_MULTIPLIER_UNIT_DEFINES_SVH
`define BOOTH_SEQUENTIAL_MULTIPLIER_UNIT_DEFINES_SVH

// implication property checked at every rising edge
`define BMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen
`define BMS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/bms_pkg.sv @@
// ----------------------------------------------------------------------------
// bms_pkg
// Shared widths, reset values and control types of the Booth multiplier.
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int MAX_WIDTH_DEFAULT = 32;
  localparam int OPND_W            = 32;
  localparam int PROD_W            = 64;
  localparam int CFG_W             = 6;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd32;

  typedef struct packed {
    logic load;
    logic step;
    logic op_en;
    logic sub;
  } step_ctrl_t;

endpackage

@@ rtl/bms_in_if.sv @@
// ----------------------------------------------------------------------------
// bms_in_if
// Operand channel: valid/ready handshake with multiplicand and multiplier.
// ----------------------------------------------------------------------------
interface bms_in_if import bms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OPND_W-1:0] multiplicand_in;
  logic signed [OPND_W-1:0] multiplier_in;

  modport source (output valid, output multiplicand_in, output multiplier_in, input ready);
  modport sink (input valid, input multiplicand_in, input multiplier_in, output ready);
endinterface

@@ rtl/bms_out_if.sv @@
// ----------------------------------------------------------------------------
// bms_out_if
// Product channel: valid/ready handshake with the signed product.
// ----------------------------------------------------------------------------
interface bms_out_if import bms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [PROD_W-1:0] product_out;

  modport source (output valid, output product_out, input ready);
  modport sink (input valid, input product_out, output ready);
endinterface

@@ rtl/bms_cell.sv @@
// ----------------------------------------------------------------------------
// bms_cell
// One bit slice: multiplicand, accumulator and multiplier bits, a full adder
// in the carry chain, and the right shift to the neighbor slice.
// ----------------------------------------------------------------------------
module bms_cell import bms_pkg::*; (
  input  logic       clk,
  input  step_ctrl_t ctrl,
  input  logic       m_init,
  input  logic       q_init,
  input  logic       carry_in,
  input  logic       sum_left,
  input  logic       q_left,
  input  logic       sum_low,
  input  logic       is_top,
  output logic       q,
  output logic       a,
  output logic       sum,
  output logic       carry_out
);

  logic m;
  logic m_eff;

  always_comb begin
    m_eff     = ctrl.op_en & (m ^ ctrl.sub);
    sum       = a ^ m_eff ^ carry_in;
    carry_out = (a & m_eff) | (carry_in & (a ^ m_eff));
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      m <= m_init;
      a <= 1'b0;
      q <= q_init;
    end else if (ctrl.step) begin
      a <= sum_left;
      q <= is_top ? sum_low : q_left;
    end
  end

endmodule

@@ rtl/bms_ctrl.sv @@
// ----------------------------------------------------------------------------
// bms_ctrl
// Step sequencer: handshakes, step counter, Booth previous bit, output valid.
// ----------------------------------------------------------------------------
`include "booth_sequential_multiplier_unit_defines.svh"

module bms_ctrl import bms_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int CNT_W    = $clog2(MAX_WIDTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  logic [CNT_W-1:0] w_eff,
  input  logic             q0,
  output logic             in_ready,
  output logic             out_valid,
  output logic             capture,
  output step_ctrl_t       ctrl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] count;
  logic             prev;
  logic             accept;
  logic             last;

  always_comb begin
    capture    = (state == ST_DONE) && (!out_valid || out_ready);
    in_ready   = (state == ST_IDLE) || capture;
    accept     = in_valid && in_ready;
    last       = (count + CNT_W'(1)) == w_eff;
    ctrl.load  = accept;
    ctrl.step  = (state == ST_RUN);
    ctrl.op_en = (state == ST_RUN) && (q0 ^ prev);
    ctrl.sub   = q0 & ~prev;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (capture) state_next = accept ? ST_RUN : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      prev      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= '0;
        prev  <= 1'b0;
      end else if (ctrl.step) begin
        count <= count + CNT_W'(1);
        prev  <= q0;
      end
      if (capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BMS_ASSERT(a_accept_starts, accept |=> (state == ST_RUN) && (count == '0), "accept did not start run")
  `BMS_ASSERT(a_step_in_range, ctrl.step |-> (count < w_eff), "step beyond operand width")
  `BMS_ASSERT(a_capture_valid, capture |=> out_valid, "captured product not presented")
  `BMS_ASSERT(a_done_holds, (state == ST_DONE) && out_valid && !out_ready |=> (state == ST_DONE), "done left while output blocked")
  `BMS_NEVER(a_no_op_idle, ctrl.op_en && !ctrl.step, "add/sub outside a step")

endmodule

@@ rtl/booth_sequential_multiplier_unit.sv @@
// ----------------------------------------------------------------------------
// booth_sequential_multiplier_unit
// Radix-2 Booth signed multiplier built as a row of bit cells.
// ----------------------------------------------------------------------------
// Each operand transaction is read as two signed numbers of w bits, where w is
// the operand_width register clamped to 1..MAX_WIDTH, and returns the full
// signed product sign-extended to 64 bits. The cell row performs one Booth
// add/subtract and arithmetic right shift per cycle while running, w steps in all;
// the product then moves into the output register once that register is free. A new
// operand transaction can be taken in the cycle its predecessor's product is captured.
// The operand side is also free while idle, even with a finished product waiting in the output register.
// Write operand_width only while the unit is idle.
module booth_sequential_multiplier_unit import bms_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  bms_in_if.sink           operand,
  bms_out_if.source        result
);

  localparam int CNT_W = $clog2(MAX_WIDTH + 1);

  logic [CFG_W-1:0]  operand_width;
  logic [CNT_W-1:0]  w_eff;
  step_ctrl_t        ctrl;
  logic              capture;
  logic              m_sign;
  logic [MAX_WIDTH:0] m_init;
  logic [MAX_WIDTH:0] q_init;
  logic [MAX_WIDTH:0] a_vec;
  logic [MAX_WIDTH:0] q_vec;
  logic [MAX_WIDTH:0] sum_vec;
  logic [MAX_WIDTH+1:0] carry_vec;
  logic [PROD_W-1:0] product_next;
  logic [PROD_W-1:0] product;

  always_ff @(posedge clk) begin
    if (rst) begin
      operand_width <= WIDTH_RESET;
    end else if (cfg_we) begin
      operand_width <= cfg_wdata;
    end
  end

  always_comb begin
    priority if (operand_width == '0) begin
      w_eff = CNT_W'(1);
    end else if (operand_width > CFG_W'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(operand_width);
    end
  end

  always_comb begin
    m_sign = 1'b0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      m_sign = m_sign | (operand.multiplicand_in[i] & (CNT_W'(i + 1) == w_eff));
    end
    for (int i = 0; i < MAX_WIDTH; i++) begin
      m_init[i] = (CNT_W'(i) < w_eff) ? operand.multiplicand_in[i] : m_sign;
      q_init[i] = (CNT_W'(i) < w_eff) & operand.multiplier_in[i];
    end
    m_init[MAX_WIDTH] = m_sign;
    q_init[MAX_WIDTH] = 1'b0;
  end

  bms_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operand.valid),
    .out_ready (result.ready),
    .w_eff     (w_eff),
    .q0        (q_vec[0]),
    .in_ready  (operand.ready),
    .out_valid (result.valid),
    .capture   (capture),
    .ctrl      (ctrl)
  );

  assign carry_vec[0] = ctrl.op_en & ctrl.sub;

  for (genvar i = 0; i <= MAX_WIDTH; i++) begin : g_cell
    logic sum_left;
    logic q_left;
    logic is_top;
    if (i == MAX_WIDTH) begin : g_guard
      assign sum_left = sum_vec[i];
      assign q_left   = 1'b0;
      assign is_top   = 1'b0;
    end else begin : g_body
      assign sum_left = sum_vec[i+1];
      assign q_left   = q_vec[i+1];
      assign is_top   = (CNT_W'(i + 1) == w_eff);
    end
    bms_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .m_init    (m_init[i]),
      .q_init    (q_init[i]),
      .carry_in  (carry_vec[i]),
      .sum_left  (sum_left),
      .q_left    (q_left),
      .sum_low   (sum_vec[0]),
      .is_top    (is_top),
      .q         (q_vec[i]),
      .a         (a_vec[i]),
      .sum       (sum_vec[i]),
      .carry_out (carry_vec[i+1])
    );
  end

  // {A, Q} with A sign-extended; Q holds the low w product bits
  assign product_next = ({{(PROD_W-MAX_WIDTH-1){a_vec[MAX_WIDTH]}}, a_vec} << w_eff)
                      | {{(PROD_W-MAX_WIDTH){1'b0}}, q_vec[MAX_WIDTH-1:0]};

  always_ff @(posedge clk) begin
    if (capture) begin
      product <= product_next;
    end
  end

  assign result.product_out = product;

endmodule
